@@ sv/glmf_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_pkg
// Shared widths, register indexes and the flush status bundle of the grid
// local maximum finder.
// ----------------------------------------------------------------------------
package glmf_pkg;

  localparam int ROW_W      = 10;  // peak row index
  localparam int COL_W      = 6;   // column index and column count
  localparam int ROWS_CFG_W = 11;  // row count register
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 11;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROW_COUNT = 2'd0,
    REG_COL_COUNT = 2'd1
  } cfg_reg_t;

  // status of the final-row flag shifter
  typedef struct packed {
    logic             busy;  // flags still being walked
    logic             hit;   // current column holds a peak
    logic             last;  // no peak left after this column
    logic [ROW_W-1:0] row;
    logic [COL_W-1:0] col;
  } flush_t;

endpackage

@@ sv/glmf_cell.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_cell
// One column slot of the two line buffers: the newer and the older sample of
// its column, written when a request lands on that column.
// ----------------------------------------------------------------------------
module glmf_cell #(
  parameter int SAMPLE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          wr_en,      // request lands on this column
  input  logic                          sel,        // this is the current column
  input  logic                          sel_right,  // this is the column to its right
  input  logic signed [SAMPLE_BITS-1:0] sample,     // fresh sample for newer line
  output logic signed [SAMPLE_BITS-1:0] new_q,      // zero unless selected
  output logic signed [SAMPLE_BITS-1:0] old_q,      // zero unless selected
  output logic signed [SAMPLE_BITS-1:0] right_q     // zero unless right of current
);

  logic signed [SAMPLE_BITS-1:0] new_r;
  logic signed [SAMPLE_BITS-1:0] old_r;
  logic signed [SAMPLE_BITS-1:0] new_nxt;
  logic signed [SAMPLE_BITS-1:0] old_nxt;

  // newer sample moves down to the older line when the column is rewritten
  always_comb begin
    new_nxt = wr_en ? sample : new_r;
    old_nxt = wr_en ? new_r : old_r;
  end

  always_ff @(posedge clk) begin
    new_r <= new_nxt;
    old_r <= old_nxt;
  end

  assign new_q   = sel ? new_r : '0;
  assign old_q   = sel ? old_r : '0;
  assign right_q = sel_right ? new_r : '0;

endmodule

@@ sv/glmf_flush.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// glmf_flush
// Final-row flag shifter: walks the peak flags of the last row one column
// per cycle, holding while a flagged column waits for take, and offers each flagged column as a result.
// ----------------------------------------------------------------------------
module glmf_flush #(
  parameter int LINE_WIDTH = 32
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  input  logic [LINE_WIDTH-1:0]          start_flags,
  input  logic [glmf_pkg::ROW_W-1:0]     start_row,
  input  logic                           take,   // result register can load
  output glmf_pkg::flush_t               status
);
  import glmf_pkg::*;

  logic                  busy_r,  busy_nxt;
  logic [LINE_WIDTH-1:0] flags_r, flags_nxt;
  logic [COL_W-1:0]      col_r,   col_nxt;
  logic [ROW_W-1:0]      row_r,   row_nxt;
  logic [LINE_WIDTH-1:0] rest;
  logic                  advance;

  always_comb begin
    rest      = flags_r >> 1;
    advance   = busy_r && (!flags_r[0] || take);
    busy_nxt  = busy_r;
    flags_nxt = flags_r;
    col_nxt   = col_r;
    row_nxt   = row_r;
    if (start) begin
      busy_nxt  = |start_flags;
      flags_nxt = start_flags;
      col_nxt   = '0;
      row_nxt   = start_row;
    end else if (advance) begin
      flags_nxt = rest;
      col_nxt   = col_r + COL_W'(1);
      busy_nxt  = |rest;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    flags_r <= flags_nxt;
    col_r   <= col_nxt;
    row_r   <= row_nxt;
  end

  assign status.busy = busy_r;
  assign status.hit  = busy_r && flags_r[0];
  assign status.last = ~|rest;
  assign status.row  = row_r;
  assign status.col  = col_r;

endmodule

@@ sv/grid_local_maximum_finder_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_local_maximum_finder_core
// Streaming 4-neighbour local maximum detector over a row-major grid.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed sample per request, row-major, frame size from config.
//   out_* : (row, col) of every cell >= each of its existing neighbours, in
//           row-major order; out_last_of_run marks the final result caused by
//           one input request. Requests that cause no result give none.
//   cfg_* : register 0 = row count, register 1 = column count; write only
//           while no request is in flight. cfg_ready is always high.
// Timing:
//   a cell above the final row is decided when the same column of the next row
//   arrives; the result sits in the output register in the cycle after that request.
//   Throughput is one sample per cycle while in_stall is low. After the last
//   sample of a frame the final-row flags are walked one column per cycle by
//   the flag shifter (held while a result waits), so in_stall stays high until the last flagged column is taken.
//   in_stall is also high while a result is held and out_stall is high.
// Reset:
//   position, final-row flags and output valid clear; registers go to one row
//   and one column. Line buffer contents are don't-care until written.
// ----------------------------------------------------------------------------
module grid_local_maximum_finder_core #(
  parameter int LINE_WIDTH  = 32,
  parameter int ROW_LIMIT   = 1024,
  parameter int SAMPLE_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // sample input
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic signed [SAMPLE_BITS-1:0]     in_sample,
  // peak output
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [glmf_pkg::ROW_W-1:0]        out_peak_row,
  output logic [glmf_pkg::COL_W-1:0]        out_peak_col,
  output logic                              out_last_of_run,
  // configuration writes
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [glmf_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [glmf_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import glmf_pkg::*;

  // configuration registers
  logic [ROWS_CFG_W-1:0] row_count_r;
  logic [COL_W-1:0]      col_count_r;
  logic [ROWS_CFG_W-1:0] rows_eff;
  logic [COL_W-1:0]      cols_eff;

  // scan position and the short history of the current and upper row
  logic [ROW_W-1:0]              row_pos_r, row_pos_nxt;
  logic [COL_W-1:0]              col_pos_r, col_pos_nxt;
  logic signed [SAMPLE_BITS-1:0] left_r;   // upper row, column c-1
  logic signed [SAMPLE_BITS-1:0] prev_r;   // current row, column c-1
  logic signed [SAMPLE_BITS-1:0] prev2_r;  // current row, column c-2
  logic [LINE_WIDTH-1:0]         flags_r, flags_nxt;

  // line buffer cells, one per column
  logic signed [SAMPLE_BITS-1:0] new_q [LINE_WIDTH];
  logic signed [SAMPLE_BITS-1:0] old_q [LINE_WIDTH];
  logic signed [SAMPLE_BITS-1:0] rgt_q [LINE_WIDTH];
  logic [LINE_WIDTH-1:0]         col_sel;
  logic [LINE_WIDTH-1:0]         right_sel;
  logic signed [SAMPLE_BITS-1:0] center;     // upper row, column c
  logic signed [SAMPLE_BITS-1:0] right_up;   // upper row, column c+1
  logic signed [SAMPLE_BITS-1:0] up_up;      // two rows up, column c

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [ROW_W-1:0] out_row_r,   out_row_nxt;
  logic [COL_W-1:0] out_col_r,   out_col_nxt;
  logic             out_last_r,  out_last_nxt;

  logic                  in_accept;
  logic                  take;
  logic                  last_col;
  logic                  final_row;
  logic                  frame_end;
  logic                  has_up, has_up2, has_left, has_left2;
  logic                  pk_above, pk_left, pk_last;
  logic [LINE_WIDTH-1:0] set_mask;
  logic [LINE_WIDTH-1:0] keep_mask;
  logic [LINE_WIDTH-1:0] flags_final;
  flush_t                flush_st;

  // ---------------- configuration ----------------
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_count_r <= ROWS_CFG_W'(1);
      col_count_r <= COL_W'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ROW_COUNT: row_count_r <= cfg_data;
        REG_COL_COUNT: col_count_r <= cfg_data[COL_W-1:0];
        default: ;
      endcase
    end
  end

  // out-of-range register values are clamped into the usable range
  always_comb begin
    if (row_count_r == '0) begin
      rows_eff = ROWS_CFG_W'(1);
    end else if (row_count_r > ROWS_CFG_W'(ROW_LIMIT)) begin
      rows_eff = ROWS_CFG_W'(ROW_LIMIT);
    end else begin
      rows_eff = row_count_r;
    end
    if (col_count_r == '0) begin
      cols_eff = COL_W'(1);
    end else if (col_count_r > COL_W'(LINE_WIDTH)) begin
      cols_eff = COL_W'(LINE_WIDTH);
    end else begin
      cols_eff = col_count_r;
    end
  end

  // ---------------- handshake ----------------
  // output register may load when empty or being drained this cycle
  assign take      = !out_valid_r || !out_stall;
  assign in_stall  = flush_st.busy || !take;
  assign in_accept = in_valid && !in_stall;

  // ---------------- line buffer cells ----------------
  // each cell keeps its own column, so a column count change inside a frame
  // still finds the upper rows by column; reads pick the current column and
  // the one to its right
  always_comb begin
    for (int i = 0; i < LINE_WIDTH; i++) begin
      col_sel[i]   = col_pos_r == COL_W'(i);
      right_sel[i] = ({1'b0, col_pos_r} + (COL_W+1)'(1)) == (COL_W+1)'(i);
    end
  end

  genvar k;
  generate
    for (k = 0; k < LINE_WIDTH; k++) begin : g_cell
      glmf_cell #(
        .SAMPLE_BITS(SAMPLE_BITS)
      ) u_cell (
        .clk       (clk),
        .wr_en     (in_accept && col_sel[k]),
        .sel       (col_sel[k]),
        .sel_right (right_sel[k]),
        .sample    (in_sample),
        .new_q     (new_q[k]),
        .old_q     (old_q[k]),
        .right_q   (rgt_q[k])
      );
    end
  endgenerate

  // unselected cells give zero, so the reads are plain ors
  always_comb begin
    center   = '0;
    up_up    = '0;
    right_up = '0;
    for (int i = 0; i < LINE_WIDTH; i++) begin
      center   = center | new_q[i];
      up_up    = up_up | old_q[i];
      right_up = right_up | rgt_q[i];
    end
  end

  // ---------------- peak decisions ----------------
  always_comb begin
    last_col  = ({1'b0, col_pos_r} + (COL_W+1)'(1)) >= {1'b0, cols_eff};
    final_row = ({1'b0, row_pos_r} + ROWS_CFG_W'(1)) >= rows_eff;
    frame_end = final_row && last_col;
    has_up    = row_pos_r != '0;
    has_up2   = row_pos_r > ROW_W'(1);
    has_left  = col_pos_r != '0;
    has_left2 = col_pos_r > COL_W'(1);

    // cell one row above the sample, now that its lower neighbour is here
    pk_above = has_up && (center >= in_sample)
               && !(has_up2 && center < up_up)
               && !(has_left && center < left_r)
               && !(!last_col && center < right_up);

    // final row: left cell now has its right neighbour
    pk_left = final_row && has_left && (prev_r >= in_sample)
              && !(has_left2 && prev_r < prev2_r)
              && !(has_up && prev_r < left_r);

    // final row, last column: the sample itself
    pk_last = frame_end
              && !(has_left && in_sample < prev_r)
              && !(has_up && in_sample < center);

    for (int i = 0; i < LINE_WIDTH; i++) begin
      set_mask[i]  = (pk_last && col_pos_r == COL_W'(i))
                     || (pk_left && col_pos_r == COL_W'(i + 1));
      // only columns up to the last one of the frame are flushed
      keep_mask[i] = COL_W'(i) <= col_pos_r;
    end
    flags_final = flags_r | set_mask;
  end

  // ---------------- position and flags ----------------
  always_comb begin
    row_pos_nxt = row_pos_r;
    col_pos_nxt = col_pos_r;
    flags_nxt   = flags_r;
    if (in_accept) begin
      if (frame_end) begin
        row_pos_nxt = '0;
        col_pos_nxt = '0;
        flags_nxt   = '0;
      end else begin
        if (final_row) begin
          flags_nxt = flags_final;
        end
        if (last_col) begin
          col_pos_nxt = '0;
          row_pos_nxt = row_pos_r + ROW_W'(1);
        end else begin
          col_pos_nxt = col_pos_r + COL_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_pos_r <= '0;
      col_pos_r <= '0;
      flags_r   <= '0;
    end else begin
      row_pos_r <= row_pos_nxt;
      col_pos_r <= col_pos_nxt;
      flags_r   <= flags_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      left_r  <= center;
      prev_r  <= in_sample;
      prev2_r <= prev_r;
    end
  end

  // ---------------- final-row flag shifter ----------------
  glmf_flush #(
    .LINE_WIDTH(LINE_WIDTH)
  ) u_flush (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (in_accept && frame_end),
    .start_flags (flags_final & keep_mask),
    .start_row   (row_pos_r),
    .take        (take),
    .status      (flush_st)
  );

  // ---------------- output register ----------------
  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    out_row_nxt   = out_row_r;
    out_col_nxt   = out_col_r;
    out_last_nxt  = out_last_r;
    priority if (in_accept && pk_above) begin
      // last of run unless a final-row flush follows
      out_valid_nxt = 1'b1;
      out_row_nxt   = row_pos_r - ROW_W'(1);
      out_col_nxt   = col_pos_r;
      out_last_nxt  = !(frame_end && |(flags_final & keep_mask));
    end else if (flush_st.hit && take) begin
      out_valid_nxt = 1'b1;
      out_row_nxt   = flush_st.row;
      out_col_nxt   = flush_st.col;
      out_last_nxt  = flush_st.last;
    end else begin
      // nothing new to load
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
    out_row_r  <= out_row_nxt;
    out_col_r  <= out_col_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_peak_row    = out_row_r;
  assign out_peak_col    = out_col_r;
  assign out_last_of_run = out_last_r;

  // ---------------- assertions ----------------
  // no sample may enter while the final row is still being flushed
  a_flush_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    flush_st.busy |-> in_stall)
    else $error("sample accepted during final-row flush");

  // only the last sample of a frame may start a flush
  a_no_flush_mid_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && !frame_end) |=> !flush_st.busy)
    else $error("flush started by a sample inside the frame");

  // a flush begins right after a frame-ending sample
  a_flush_after_frame_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(flush_st.busy) |-> $past(in_accept && frame_end))
    else $error("flush started without a frame end");

endmodule
